[rtl/core/health_aware_round_robin_selector_defines.svh]
// ----------------------------------------------------------------------------
// health aware round robin selector assertion macros
// concurrent assertion helpers clocked on clk_i, disabled during reset
// ----------------------------------------------------------------------------
`ifndef HEALTH_AWARE_ROUND_ROBIN_SELECTOR_DEFINES_SVH
`define HEALTH_AWARE_ROUND_ROBIN_SELECTOR_DEFINES_SVH

// same cycle implication
`define HARRS_ASSERT_NOW(label, ante, cons) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error("assertion failed: label");

// next cycle implication
`define HARRS_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error("assertion failed: label");

`endif

[rtl/core/harrs_pkg.sv]
// ----------------------------------------------------------------------------
// harrs_pkg
// shared constants, codes and controller interface types of the selector
// ----------------------------------------------------------------------------
package harrs_pkg;

  localparam int unsigned NUM_SERVERS = 8;
  localparam int unsigned SLOTS       = 8;
  localparam int unsigned CNT_W       = 4;
  localparam int unsigned IDX_W       = 3;
  localparam int unsigned ID_W        = 8;
  localparam int unsigned TABLE_W     = SLOTS * ID_W;
  localparam int unsigned CFG_IDX_W   = 2;

  localparam logic [CNT_W-1:0] COUNT_RESET = CNT_W'(8);

  typedef enum logic [1:0] {
    H_GOOD      = 2'd0,
    H_GOOD_WAIT = 2'd1,
    H_BAD       = 2'd2,
    H_BAD_WAIT  = 2'd3
  } health_e;

  typedef enum logic [1:0] {
    ACT_PICK  = 2'd0,
    ACT_SEND  = 2'd1,
    ACT_REPLY = 2'd2,
    ACT_SWEEP = 2'd3
  } action_e;

  localparam logic [CFG_IDX_W-1:0] CFG_SERVER_COUNT = CFG_IDX_W'(0);
  localparam logic [CFG_IDX_W-1:0] CFG_ID_TABLE     = CFG_IDX_W'(1);

  typedef struct packed {
    logic start;
    logic step;
    logic emit;
  } cmd_t;

  typedef struct packed {
    logic scan_req;
    logic hit;
    logic last;
  } sts_t;

  function automatic logic [CNT_W-1:0] eff_count(logic [CNT_W-1:0] c);
    logic [CNT_W-1:0] lim;
    lim = CNT_W'(NUM_SERVERS);
    return (c > lim) ? lim : c;
  endfunction

endpackage

[rtl/core/harrs_ctrl.sv]
// ----------------------------------------------------------------------------
// harrs_ctrl
// sequencer: accepts a transaction, runs the pick scan when one is needed, hands off the result
// ----------------------------------------------------------------------------
module harrs_ctrl (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             in_valid_i,
  output logic             in_ready_o,
  output logic             out_valid_o,
  input  logic             out_ready_i,
  input  harrs_pkg::sts_t  sts_i,
  output harrs_pkg::cmd_t  cmd_o
);

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SCAN,
    ST_HOLD
  } state_e;

  state_e state_q;
  logic   out_valid_q;
  logic   can_emit;

  assign can_emit    = !out_valid_q || out_ready_i;
  assign in_ready_o  = (state_q == ST_IDLE);
  assign out_valid_o = out_valid_q;

  always_comb begin
    cmd_o.start = (state_q == ST_IDLE) && in_valid_i;
    cmd_o.step  = (state_q == ST_SCAN);
    cmd_o.emit  = (state_q == ST_HOLD) && can_emit;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      out_valid_q <= 1'b0;
    end else begin
      if (cmd_o.emit) begin
        out_valid_q <= 1'b1;
      end else if (out_valid_q && out_ready_i) begin
        out_valid_q <= 1'b0;
      end
      unique case (state_q)
        ST_IDLE: begin
          if (in_valid_i) begin
            state_q <= sts_i.scan_req ? ST_SCAN : ST_HOLD;
          end
        end
        ST_SCAN: begin
          if (sts_i.hit || sts_i.last) begin
            state_q <= ST_HOLD;
          end
        end
        ST_HOLD: begin
          if (can_emit) begin
            state_q <= ST_IDLE;
          end
        end
        default: state_q <= ST_IDLE;
      endcase
    end
  end

endmodule

[rtl/core/harrs_dp.sv]
// ----------------------------------------------------------------------------
// harrs_dp
// health table, round robin pointer, config registers, scan and result regs
// ----------------------------------------------------------------------------
module harrs_dp (
  input  logic                                 clk_i,
  input  logic                                 rst_ni,
  input  harrs_pkg::cmd_t                      cmd_i,
  output harrs_pkg::sts_t                      sts_o,
  input  logic                                 cfg_valid_i,
  input  logic [harrs_pkg::CFG_IDX_W-1:0]      cfg_index_i,
  input  logic [harrs_pkg::TABLE_W-1:0]        cfg_data_i,
  input  logic [1:0]                           action_i,
  input  logic [harrs_pkg::IDX_W-1:0]          server_index_i,
  input  logic                                 send_ok_i,
  input  logic [harrs_pkg::ID_W-1:0]           reply_server_id_i,
  output logic                                 pick_valid_o,
  output logic [harrs_pkg::IDX_W-1:0]          picked_index_o,
  output logic [harrs_pkg::ID_W-1:0]           picked_id_o,
  output logic [harrs_pkg::SLOTS-1:0]          usable_mask_o
);

  harrs_pkg::health_e                  health_q [harrs_pkg::SLOTS];
  logic [harrs_pkg::CNT_W-1:0]         count_q;
  logic [harrs_pkg::TABLE_W-1:0]       idtab_q;
  logic [harrs_pkg::CNT_W-1:0]         ptr_q;
  logic                                pinv_q;
  logic [harrs_pkg::IDX_W-1:0]         cand_q;
  logic [harrs_pkg::CNT_W-1:0]         cnt_q;
  logic                                res_valid_q;
  logic [harrs_pkg::IDX_W-1:0]         res_idx_q;
  logic [harrs_pkg::ID_W-1:0]          res_id_q;

  logic [harrs_pkg::CNT_W-1:0]         c_eff;
  logic [harrs_pkg::CNT_W-1:0]         cfg_c_eff;
  logic [harrs_pkg::CNT_W-1:0]         start;
  logic [harrs_pkg::IDX_W-1:0]         first_cand;
  logic [harrs_pkg::IDX_W-1:0]         next_cand;
  logic [harrs_pkg::SLOTS-1:0]         usable;
  logic [harrs_pkg::SLOTS-1:0]         mask;
  logic [harrs_pkg::SLOTS-1:0]         match_hit;
  logic [harrs_pkg::ID_W-1:0]          cand_id;
  logic                                cand_hit;
  logic                                scan_last;
  logic                                in_range;

  assign c_eff     = harrs_pkg::eff_count(count_q);
  assign cfg_c_eff = harrs_pkg::eff_count(cfg_data_i[harrs_pkg::CNT_W-1:0]);

  always_comb begin
    for (int k = 0; k < harrs_pkg::SLOTS; k++) begin
      usable[k] = (health_q[k] == harrs_pkg::H_GOOD) ||
                  (health_q[k] == harrs_pkg::H_GOOD_WAIT);
      mask[k]   = usable[k] && (harrs_pkg::CNT_W'(k) < c_eff);
    end
  end

  // lowest matching server in use
  always_comb begin
    logic found;
    found = 1'b0;
    for (int k = 0; k < harrs_pkg::SLOTS; k++) begin
      match_hit[k] = 1'b0;
      if (!found && (harrs_pkg::CNT_W'(k) < c_eff) &&
          (idtab_q[k*harrs_pkg::ID_W +: harrs_pkg::ID_W] == reply_server_id_i)) begin
        match_hit[k] = 1'b1;
        found        = 1'b1;
      end
    end
  end

  always_comb begin
    start      = (pinv_q || (ptr_q >= c_eff)) ? (c_eff - 1'b1) : ptr_q;
    first_cand = (start == c_eff - 1'b1) ? '0 : harrs_pkg::IDX_W'(start + 1'b1);
    next_cand  = (harrs_pkg::CNT_W'(cand_q) == c_eff - 1'b1) ? '0 : cand_q + 1'b1;
    cand_hit   = usable[cand_q];
    cand_id    = idtab_q[cand_q*harrs_pkg::ID_W +: harrs_pkg::ID_W];
    scan_last  = ((cnt_q + 1'b1) == c_eff);
    in_range   = ({1'b0, server_index_i} < c_eff);
  end

  assign sts_o.scan_req = (action_i == harrs_pkg::ACT_PICK) && (c_eff != '0);
  assign sts_o.hit      = cand_hit;
  assign sts_o.last     = scan_last;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int k = 0; k < harrs_pkg::SLOTS; k++) begin
        health_q[k] <= harrs_pkg::H_GOOD;
      end
      count_q <= harrs_pkg::COUNT_RESET;
      idtab_q <= '0;
      ptr_q   <= harrs_pkg::eff_count(harrs_pkg::COUNT_RESET) - 1'b1;
      pinv_q  <= 1'b0;
    end else begin
      if (cfg_valid_i) begin
        unique case (cfg_index_i)
          harrs_pkg::CFG_SERVER_COUNT: begin
            count_q <= cfg_data_i[harrs_pkg::CNT_W-1:0];
            ptr_q   <= (cfg_c_eff == '0) ? '0 : cfg_c_eff - 1'b1;
            pinv_q  <= (cfg_c_eff == '0);
          end
          harrs_pkg::CFG_ID_TABLE: idtab_q <= cfg_data_i;
          default: ;
        endcase
      end
      if (cmd_i.start) begin
        unique case (action_i)
          harrs_pkg::ACT_PICK: begin
            if (c_eff == '0) begin
              pinv_q <= 1'b1;
            end
          end
          harrs_pkg::ACT_SEND: begin
            if (in_range) begin
              if (!send_ok_i) begin
                health_q[server_index_i] <= harrs_pkg::H_BAD;
              end else if (health_q[server_index_i] == harrs_pkg::H_GOOD) begin
                health_q[server_index_i] <= harrs_pkg::H_GOOD_WAIT;
              end else if (health_q[server_index_i] == harrs_pkg::H_BAD) begin
                health_q[server_index_i] <= harrs_pkg::H_BAD_WAIT;
              end
            end
          end
          harrs_pkg::ACT_REPLY: begin
            for (int k = 0; k < harrs_pkg::SLOTS; k++) begin
              if (match_hit[k]) begin
                health_q[k] <= harrs_pkg::H_GOOD;
              end
            end
          end
          harrs_pkg::ACT_SWEEP: begin
            for (int k = 0; k < harrs_pkg::SLOTS; k++) begin
              if ((harrs_pkg::CNT_W'(k) < c_eff) && (health_q[k] != harrs_pkg::H_GOOD)) begin
                health_q[k] <= harrs_pkg::H_BAD;
              end
            end
          end
          default: ;
        endcase
      end
      if (cmd_i.step) begin
        if (cand_hit) begin
          ptr_q  <= harrs_pkg::CNT_W'(cand_q);
          pinv_q <= 1'b0;
        end else if (scan_last) begin
          pinv_q <= 1'b1;
        end
      end
    end
  end

  // scan, result and output registers, no reset needed
  always_ff @(posedge clk_i) begin
    if (cmd_i.start) begin
      cand_q      <= first_cand;
      cnt_q       <= '0;
      res_valid_q <= 1'b0;
      res_idx_q   <= '0;
      res_id_q    <= '0;
    end else if (cmd_i.step) begin
      if (cand_hit) begin
        res_valid_q <= 1'b1;
        res_idx_q   <= cand_q;
        res_id_q    <= cand_id;
      end else begin
        cand_q <= next_cand;
        cnt_q  <= cnt_q + 1'b1;
      end
    end
    if (cmd_i.emit) begin
      pick_valid_o   <= res_valid_q;
      picked_index_o <= res_idx_q;
      picked_id_o    <= res_id_q;
      usable_mask_o  <= mask;
    end
  end

endmodule

[rtl/core/health_aware_round_robin_selector.sv]
// send, reply and sweep go straight to the hold state, which emits their result into the output register
// a pick with a nonzero server count first scans from the server after the pointer until a usable one or the last
// one transaction in flight: in_ready_o stays low until its result is emitted to the output register
// a new transaction is taken while the previous result waits in the output register
// reset: all servers good, server count 8, pointer on server 7, id table zero
`include "health_aware_round_robin_selector_defines.svh"
// ----------------------------------------------------------------------------
// health_aware_round_robin_selector
// round robin back end picker with per server heartbeat health tracking
// ----------------------------------------------------------------------------
module health_aware_round_robin_selector (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  logic                             cfg_valid_i,
  output logic                             cfg_ready_o,
  input  logic [harrs_pkg::CFG_IDX_W-1:0]  cfg_index_i,
  input  logic [harrs_pkg::TABLE_W-1:0]    cfg_data_i,
  input  logic                             in_valid_i,
  output logic                             in_ready_o,
  input  logic [1:0]                       action_i,
  input  logic [harrs_pkg::IDX_W-1:0]      server_index_i,
  input  logic                             send_ok_i,
  input  logic [harrs_pkg::ID_W-1:0]       reply_server_id_i,
  output logic                             out_valid_o,
  input  logic                             out_ready_i,
  output logic                             pick_valid_o,
  output logic [harrs_pkg::IDX_W-1:0]      picked_index_o,
  output logic [harrs_pkg::ID_W-1:0]       picked_id_o,
  output logic [harrs_pkg::SLOTS-1:0]      usable_mask_o
);

  harrs_pkg::cmd_t cmd;
  harrs_pkg::sts_t sts;

  assign cfg_ready_o = 1'b1;

  harrs_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .sts_i       (sts),
    .cmd_o       (cmd)
  );

  harrs_dp u_dp (
    .clk_i             (clk_i),
    .rst_ni            (rst_ni),
    .cmd_i             (cmd),
    .sts_o             (sts),
    .cfg_valid_i       (cfg_valid_i),
    .cfg_index_i       (cfg_index_i),
    .cfg_data_i        (cfg_data_i),
    .action_i          (action_i),
    .server_index_i    (server_index_i),
    .send_ok_i         (send_ok_i),
    .reply_server_id_i (reply_server_id_i),
    .pick_valid_o      (pick_valid_o),
    .picked_index_o    (picked_index_o),
    .picked_id_o       (picked_id_o),
    .usable_mask_o     (usable_mask_o)
  );

  `HARRS_ASSERT_NOW(a_pick_is_usable, out_valid_o && pick_valid_o, usable_mask_o[picked_index_o])
  `HARRS_ASSERT_NOW(a_no_pick_zero, out_valid_o && !pick_valid_o, ~|{picked_index_o, picked_id_o})
  `HARRS_ASSERT_NEXT(a_one_in_flight, in_valid_i && in_ready_o, !in_ready_o)

endmodule
